@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`endif

@@ hdl/atsd_pkg.sv @@
// Shared types, widths, constants and the arctangent table of the detector.
package atsd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int FIX_W      = 18;
  localparam int SQ_W       = 36;
  localparam int MAG_W      = 18;
  localparam int ANG_W      = 26;
  localparam int DEG_W      = 8;
  localparam int IRQ_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_TILT_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd2;

  localparam int IRQ_SINGLE_TAP = 6;
  localparam int IRQ_DOUBLE_TAP = 5;

  localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd11796480;
  localparam logic [DEG_W-1:0]        DEG_MAX   = 8'd180;
  localparam logic [8:0]              ALPHA_ONE = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WIN, ST_DIV_GO, ST_DIV, ST_TILT, ST_FMUL, ST_FADD, ST_SQR,
    ST_SQRT_GO, ST_SQRT, ST_ROLL_GO, ST_ROLL, ST_PITCH_GO, ST_PITCH, ST_FIN
  } state_t;

  // Arctangent of 2^-i in degrees scaled by 65536.
  function automatic logic [ANG_W-1:0] atan_q16(input logic [3:0] i);
    logic [ANG_W-1:0] a;
    case (i)
      4'd0:    a = 26'd2949120;
      4'd1:    a = 26'd1740967;
      4'd2:    a = 26'd919879;
      4'd3:    a = 26'd466945;
      4'd4:    a = 26'd234379;
      4'd5:    a = 26'd117304;
      4'd6:    a = 26'd58666;
      4'd7:    a = 26'd29335;
      4'd8:    a = 26'd14668;
      4'd9:    a = 26'd7334;
      4'd10:   a = 26'd3667;
      4'd11:   a = 26'd1833;
      4'd12:   a = 26'd917;
      4'd13:   a = 26'd458;
      4'd14:   a = 26'd229;
      4'd15:   a = 26'd115;
      default: a = 26'd0;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/atsd_if.sv @@
// Sample and result channel interfaces.
interface atsd_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [atsd_pkg::SAMPLE_W-1:0]  accel_x;
  logic signed [atsd_pkg::SAMPLE_W-1:0]  accel_y;
  logic signed [atsd_pkg::SAMPLE_W-1:0]  accel_z;
  logic [atsd_pkg::IRQ_W-1:0]            irq_source;
  modport source(output valid, accel_x, accel_y, accel_z, irq_source, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, irq_source, output ready);
endinterface

interface atsd_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [atsd_pkg::SAMPLE_W-1:0]  avg_x;
  logic signed [atsd_pkg::SAMPLE_W-1:0]  avg_y;
  logic signed [atsd_pkg::SAMPLE_W-1:0]  avg_z;
  logic                                  tilted;
  logic [1:0]                            tilt_axes;
  logic [atsd_pkg::DEG_W-1:0]            tilt_degrees;
  logic                                  single_tap;
  logic                                  double_tap;
  logic                                  shaken;
  modport source(output valid, avg_x, avg_y, avg_z, tilted, tilt_axes, tilt_degrees,
                 single_tap, double_tap, shaken, input ready);
  modport sink(input valid, avg_x, avg_y, avg_z, tilted, tilt_axes, tilt_degrees,
               single_tap, double_tap, shaken, output ready);
endinterface

@@ hdl/atsd_div.sv @@
// Bit-serial restoring divider of a window sum by the window depth.
module atsd_div #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [atsd_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] sum,
  output logic                                 done,
  output logic signed [atsd_pkg::SAMPLE_W-1:0] quot
);
  localparam int SUM_W = atsd_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int REM_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam logic [REM_W:0] DIVISOR = (REM_W+1)'(WINDOW_DEPTH);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] dvd;
  logic [REM_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic             neg;
  logic [REM_W:0]   trial;
  logic             ge;

  assign trial = {rem, dvd[SUM_W-1]};
  assign ge    = trial >= DIVISOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= sum[SUM_W-1];
        dvd  <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        rem <= ge ? REM_W'(trial - DIVISOR) : REM_W'(trial);
        quo <= {quo[SUM_W-2:0], ge};
        dvd <= {dvd[SUM_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign quot = neg ? -$signed(quo[atsd_pkg::SAMPLE_W-1:0])
                    : $signed(quo[atsd_pkg::SAMPLE_W-1:0]);
endmodule

@@ hdl/atsd_isqrt.sv @@
// Floor integer square root, two radicand bits per cycle.
module atsd_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [atsd_pkg::SQ_W-1:0]     radicand,
  output logic                          done,
  output logic [atsd_pkg::MAG_W-1:0]    root
);
  localparam int RT_W  = atsd_pkg::MAG_W;
  localparam int REM_W = RT_W + 2;
  localparam int CUR_W = REM_W + 2;

  logic                         busy;
  logic [4:0]                   cnt;
  logic [atsd_pkg::SQ_W-1:0]    v;
  logic [REM_W-1:0]             rem;
  logic [CUR_W-1:0]             cur;
  logic [CUR_W-1:0]             trial;

  assign cur   = {rem, v[atsd_pkg::SQ_W-1 -: 2]};
  assign trial = CUR_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        if (cur >= trial) begin
          rem  <= REM_W'(cur - trial);
          root <= {root[RT_W-2:0], 1'b1};
        end else begin
          rem  <= REM_W'(cur);
          root <= {root[RT_W-2:0], 1'b0};
        end
        v   <= {v[atsd_pkg::SQ_W-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (cnt == 5'(RT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hdl/atsd_cordic.sv @@
// CORDIC vectoring unit giving atan2 in degrees times 65536, one step per cycle.
module atsd_cordic #(
  parameter int CORDIC_STEPS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [atsd_pkg::FIX_W:0]   y_in,
  input  logic signed [atsd_pkg::FIX_W:0]   x_in,
  output logic                              done,
  output logic signed [atsd_pkg::ANG_W-1:0] angle
);
  localparam int W = 34;

  logic                              busy;
  logic                              zero;
  logic [3:0]                        step;
  logic signed [W-1:0]               x;
  logic signed [W-1:0]               y;
  logic signed [atsd_pkg::ANG_W-1:0] z;
  logic signed [W-1:0]               xs;
  logic signed [W-1:0]               ys;
  logic signed [W-1:0]               dx;
  logic signed [W-1:0]               dy;
  logic signed [atsd_pkg::ANG_W-1:0] at;

  assign xs = W'(x_in) <<< 12;
  assign ys = W'(y_in) <<< 12;
  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = $signed(atsd_pkg::atan_q16(step));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        zero <= (x_in == '0) && (y_in == '0);
        // A vector in the left half plane is turned by half a turn first.
        if (x_in < 0) begin
          x <= -xs;
          y <= -ys;
          z <= (y_in >= 0) ? atsd_pkg::HALF_TURN : -atsd_pkg::HALF_TURN;
        end else begin
          x <= xs;
          y <= ys;
          z <= '0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end
        step <= step + 1'b1;
        if (step == 4'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign angle = zero ? '0 : z;
endmodule

@@ hdl/accel_tilt_shake_tap_detector_unit.sv @@
// Top level of the tilt, shake and tap detector.
// One word is taken at a time; the input is ready again once the result is registered.
// Each word passes the window update, then the serial dividers, whose length is set
// by SUM_W = 10 + clog2(WINDOW_DEPTH), then the tilt check, then the output register.
// A tilted word passes the filter, square root and roll and pitch CORDIC runs in between.
// A result that stalls at the output holds back the next word.
// Synchronous reset clears the window, sums, filter state and handshakes and loads the config defaults.
`include "assert_macros.svh"
module accel_tilt_shake_tap_detector_unit #(
  parameter int WINDOW_DEPTH = 8,
  parameter int CORDIC_STEPS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [atsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [atsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  atsd_sample_if.sink                         sample,
  atsd_result_if.source                       result
);
  localparam int SW     = atsd_pkg::SAMPLE_W;
  localparam int FW     = atsd_pkg::FIX_W;
  localparam int SUM_W  = SW + $clog2(WINDOW_DEPTH);
  localparam int SLOT_W = $clog2(WINDOW_DEPTH);

  atsd_pkg::state_t state, state_next;

  logic [8:0]                   tilt_thr;
  logic [9:0]                   shake_thr;
  logic [8:0]                   alpha;

  logic signed [SW-1:0]         nx, ny, nz;
  logic [atsd_pkg::IRQ_W-1:0]   irq;
  logic signed [SW-1:0]         prev_x, prev_y;
  logic signed [SW-1:0]         win_x [WINDOW_DEPTH];
  logic signed [SW-1:0]         win_y [WINDOW_DEPTH];
  logic signed [SW-1:0]         win_z [WINDOW_DEPTH];
  logic [SLOT_W-1:0]            slot, slot_next;
  logic signed [SUM_W-1:0]      sum_x, sum_y, sum_z;
  logic signed [FW-1:0]         sm [3];
  logic                         shk;

  logic                         div_start;
  logic                         div_done_x, div_done_y, div_done_z;
  logic signed [SW-1:0]         q_x, q_y, q_z;
  logic signed [SW-1:0]         avg_x, avg_y, avg_z;
  logic [1:0]                   axes;
  logic [SW-1:0]                abs_x, abs_y;

  logic [1:0]                   k;
  logic [8:0]                   a_sat, a_inv;
  logic signed [SW-1:0]         raw_k;
  logic signed [FW-1:0]         sm_k;
  logic signed [19:0]           p1;
  logic signed [27:0]           p2;
  logic signed [28:0]           t_sum;

  logic signed [35:0]           sq_y, sq_z;
  logic                         sqrt_start, sqrt_done;
  logic [atsd_pkg::MAG_W-1:0]   mag;

  logic                         cor_start, cor_done;
  logic signed [FW:0]           cor_y, cor_x;
  logic signed [atsd_pkg::ANG_W-1:0] cor_angle;
  logic [atsd_pkg::ANG_W-1:0]   roll_abs, pitch_abs, ang_max;
  logic [9:0]                   deg_raw;
  logic [atsd_pkg::DEG_W-1:0]   degrees;

  logic signed [SW:0]           dxs, dys;
  logic [SW:0]                  adx, ady;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_thr  <= 9'd100;
      shake_thr <= 10'd100;
      alpha     <= 9'd26;
    end else if (cfg_we) begin
      case (cfg_index)
        atsd_pkg::REG_TILT_THR:  tilt_thr  <= cfg_data[8:0];
        atsd_pkg::REG_SHAKE_THR: shake_thr <= cfg_data[9:0];
        atsd_pkg::REG_ALPHA:     alpha     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign slot_next = (slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot + 1'b1;

  assign dxs = (SW+1)'(nx) - (SW+1)'(prev_x);
  assign dys = (SW+1)'(ny) - (SW+1)'(prev_y);
  assign adx = dxs[SW] ? (SW+1)'(-dxs) : (SW+1)'(dxs);
  assign ady = dys[SW] ? (SW+1)'(-dys) : (SW+1)'(dys);

  assign abs_x = q_x[SW-1] ? SW'(-q_x) : SW'(q_x);
  assign abs_y = q_y[SW-1] ? SW'(-q_y) : SW'(q_y);

  assign a_sat = (alpha > atsd_pkg::ALPHA_ONE) ? atsd_pkg::ALPHA_ONE : alpha;
  assign a_inv = atsd_pkg::ALPHA_ONE - a_sat;
  assign raw_k = (k == 2'd0) ? nx : (k == 2'd1) ? ny : nz;
  assign sm_k  = sm[k];
  assign t_sum = (29'(p1) <<< 8) + 29'(p2) + 29'sd128;

  assign div_start  = (state == atsd_pkg::ST_DIV_GO);
  assign sqrt_start = (state == atsd_pkg::ST_SQRT_GO);
  assign cor_start  = (state == atsd_pkg::ST_ROLL_GO) || (state == atsd_pkg::ST_PITCH_GO);
  assign cor_y = (state == atsd_pkg::ST_ROLL_GO) ? -(FW+1)'(sm[1]) : (FW+1)'(sm[0]);
  assign cor_x = (state == atsd_pkg::ST_ROLL_GO) ? (FW+1)'(sm[2])
                                                 : $signed({1'b0, mag});

  assign pitch_abs = cor_angle[atsd_pkg::ANG_W-1] ? atsd_pkg::ANG_W'(-cor_angle)
                                                  : atsd_pkg::ANG_W'(cor_angle);
  assign ang_max   = (roll_abs > pitch_abs) ? roll_abs : pitch_abs;
  assign deg_raw   = ang_max[25:16];

  atsd_div #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .sum(sum_x), .done(div_done_x), .quot(q_x));
  atsd_div #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .sum(sum_y), .done(div_done_y), .quot(q_y));
  atsd_div #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_div_z (
    .clk(clk), .rst(rst), .start(div_start), .sum(sum_z), .done(div_done_z), .quot(q_z));

  atsd_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sqrt_start),
    .radicand(atsd_pkg::SQ_W'(sq_y) + atsd_pkg::SQ_W'(sq_z)),
    .done(sqrt_done), .root(mag));

  atsd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .y_in(cor_y), .x_in(cor_x),
    .done(cor_done), .angle(cor_angle));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      atsd_pkg::ST_IDLE:     if (sample.valid) state_next = atsd_pkg::ST_WIN;
      atsd_pkg::ST_WIN:      state_next = atsd_pkg::ST_DIV_GO;
      atsd_pkg::ST_DIV_GO:   state_next = atsd_pkg::ST_DIV;
      atsd_pkg::ST_DIV:      if (div_done_x && div_done_y && div_done_z) begin
                               state_next = atsd_pkg::ST_TILT;
                             end
      atsd_pkg::ST_TILT:     state_next = (axes != 2'd0) ? atsd_pkg::ST_FMUL
                                                         : atsd_pkg::ST_FIN;
      atsd_pkg::ST_FMUL:     state_next = atsd_pkg::ST_FADD;
      atsd_pkg::ST_FADD:     state_next = (k == 2'd2) ? atsd_pkg::ST_SQR : atsd_pkg::ST_FMUL;
      atsd_pkg::ST_SQR:      state_next = atsd_pkg::ST_SQRT_GO;
      atsd_pkg::ST_SQRT_GO:  state_next = atsd_pkg::ST_SQRT;
      atsd_pkg::ST_SQRT:     if (sqrt_done) state_next = atsd_pkg::ST_ROLL_GO;
      atsd_pkg::ST_ROLL_GO:  state_next = atsd_pkg::ST_ROLL;
      atsd_pkg::ST_ROLL:     if (cor_done) state_next = atsd_pkg::ST_PITCH_GO;
      atsd_pkg::ST_PITCH_GO: state_next = atsd_pkg::ST_PITCH;
      atsd_pkg::ST_PITCH:    if (cor_done) state_next = atsd_pkg::ST_FIN;
      atsd_pkg::ST_FIN:      if (!result.valid || result.ready) begin
                               state_next = atsd_pkg::ST_IDLE;
                             end
      default:               state_next = atsd_pkg::ST_IDLE;
    endcase
  end

  assign sample.ready = (state == atsd_pkg::ST_IDLE);

  // Datapath state that reset must clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot   <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_z  <= '0;
      prev_x <= '0;
      prev_y <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_x[i] <= '0;
        win_y[i] <= '0;
        win_z[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        sm[i] <= '0;
      end
    end else begin
      if (state == atsd_pkg::ST_WIN) begin
        slot   <= slot_next;
        sum_x  <= sum_x + SUM_W'(nx) - SUM_W'(win_x[slot_next]);
        sum_y  <= sum_y + SUM_W'(ny) - SUM_W'(win_y[slot_next]);
        sum_z  <= sum_z + SUM_W'(nz) - SUM_W'(win_z[slot_next]);
        win_x[slot_next] <= nx;
        win_y[slot_next] <= ny;
        win_z[slot_next] <= nz;
        prev_x <= nx;
        prev_y <= ny;
      end
      if (state == atsd_pkg::ST_FADD) begin
        sm[k] <= FW'(t_sum >>> 8);
      end
    end
  end

  // Payload registers of the working item.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      nx  <= sample.accel_x;
      ny  <= sample.accel_y;
      nz  <= sample.accel_z;
      irq <= sample.irq_source;
    end
    if (state == atsd_pkg::ST_WIN) begin
      shk <= (adx > (SW+1)'(shake_thr)) || (ady > (SW+1)'(shake_thr));
    end
    if (state == atsd_pkg::ST_DIV) begin
      avg_x <= q_x;
      avg_y <= q_y;
      avg_z <= q_z;
      axes  <= {abs_y > SW'(tilt_thr), abs_x > SW'(tilt_thr)};
    end
    if (state == atsd_pkg::ST_TILT) begin
      k       <= 2'd0;
      degrees <= '0;
    end
    if (state == atsd_pkg::ST_FMUL) begin
      p1 <= raw_k * $signed({1'b0, a_sat});
      p2 <= sm_k * $signed({1'b0, a_inv});
    end
    if (state == atsd_pkg::ST_FADD) begin
      k <= k + 1'b1;
    end
    if (state == atsd_pkg::ST_SQR) begin
      sq_y <= sm[1] * sm[1];
      sq_z <= sm[2] * sm[2];
    end
    if (state == atsd_pkg::ST_ROLL && cor_done) begin
      roll_abs <= pitch_abs;
    end
    if (state == atsd_pkg::ST_PITCH && cor_done) begin
      degrees <= (deg_raw > 10'(atsd_pkg::DEG_MAX)) ? atsd_pkg::DEG_MAX
                                                    : deg_raw[atsd_pkg::DEG_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == atsd_pkg::ST_FIN && (!result.valid || result.ready)) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == atsd_pkg::ST_FIN && (!result.valid || result.ready)) begin
      result.avg_x        <= avg_x;
      result.avg_y        <= avg_y;
      result.avg_z        <= avg_z;
      result.tilted       <= (axes != 2'd0);
      result.tilt_axes    <= axes;
      result.tilt_degrees <= degrees;
      result.double_tap   <= irq[atsd_pkg::IRQ_DOUBLE_TAP];
      result.single_tap   <= irq[atsd_pkg::IRQ_SINGLE_TAP] && !irq[atsd_pkg::IRQ_DOUBLE_TAP];
      result.shaken       <= shk;
    end
  end

  `ASSERT_NXT(a_accept_to_window, clk, rst, sample.valid && sample.ready, state == atsd_pkg::ST_WIN)
  `ASSERT_IMP(a_flat_no_degrees, clk, rst, result.valid && !result.tilted, result.tilt_degrees == '0)
  `ASSERT_IMP(a_degrees_limit, clk, rst, result.valid, result.tilt_degrees <= atsd_pkg::DEG_MAX)
  `ASSERT_IMP(a_tap_exclusive, clk, rst, result.valid, !(result.single_tap && result.double_tap))
endmodule

@@ bench/tb_accel_tilt_shake_tap_detector_unit.sv @@
// Testbench for the tilt, shake and tap detector: self-checking against an in-bench predictor.
`timescale 1ns / 1ps
module tb_accel_tilt_shake_tap_detector_unit;

  localparam int DEPTH = 8;
  localparam int STEPS = 12;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [atsd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [atsd_pkg::SAMPLE_W-1:0] avg_x;
    logic signed [atsd_pkg::SAMPLE_W-1:0] avg_y;
    logic signed [atsd_pkg::SAMPLE_W-1:0] avg_z;
    logic                                 tilted;
    logic [1:0]                           tilt_axes;
    logic [atsd_pkg::DEG_W-1:0]           tilt_degrees;
    logic                                 single_tap;
    logic                                 double_tap;
    logic                                 shaken;
  } motion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [atsd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [atsd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  atsd_sample_if sample();
  atsd_result_if result();

  accel_tilt_shake_tap_detector_unit #(.WINDOW_DEPTH(DEPTH), .CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample(sample), .result(result)
  );

  always #6 clk = ~clk;

  // Predictor state.
  int unsigned tilt_thr, shake_thr, alpha;
  int win_x[DEPTH], win_y[DEPTH], win_z[DEPTH];
  int slot;
  int sum_x, sum_y, sum_z;
  int prev_x, prev_y;
  longint filt[3];

  motion_t expected_motion[$];
  int errors = 0;
  int words_in = 0, words_out = 0, tilted_seen = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  const longint ATAN_TAB[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint atan2_deg(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void predictor_reset();
    tilt_thr = 100; shake_thr = 100; alpha = 26;
    foreach (win_x[i]) begin
      win_x[i] = 0; win_y[i] = 0; win_z[i] = 0;
    end
    slot = 0; sum_x = 0; sum_y = 0; sum_z = 0; prev_x = 0; prev_y = 0;
    foreach (filt[i]) filt[i] = 0;
  endfunction

  function automatic motion_t predict_motion(int nx, int ny, int nz, logic [7:0] irq);
    motion_t m;
    int ax, ay, az, dx, dy;
    logic [1:0] axes;
    longint a, t, roll, pitch, big, mg;
    int raw[3];
    dx = nx - prev_x; dy = ny - prev_y;
    prev_x = nx; prev_y = ny;
    slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
    sum_x += nx - win_x[slot]; sum_y += ny - win_y[slot]; sum_z += nz - win_z[slot];
    win_x[slot] = nx; win_y[slot] = ny; win_z[slot] = nz;
    ax = sum_x / DEPTH; ay = sum_y / DEPTH; az = sum_z / DEPTH;
    axes = '0;
    if (mag(ax) > tilt_thr) axes[0] = 1'b1;
    if (mag(ay) > tilt_thr) axes[1] = 1'b1;
    m = '0;
    if (axes != 0) begin
      a = alpha > 256 ? 256 : alpha;
      raw[0] = nx; raw[1] = ny; raw[2] = nz;
      for (int k = 0; k < 3; k++) begin
        t = longint'(raw[k]) * 256 * a + filt[k] * (256 - a) + 128;
        filt[k] = t >>> 8;
      end
      mg = int_sqrt(filt[1] * filt[1] + filt[2] * filt[2]);
      roll = mag(atan2_deg(-filt[1], filt[2]));
      pitch = mag(atan2_deg(filt[0], mg));
      big = (roll > pitch ? roll : pitch) >>> 16;
      m.tilt_degrees = big > 180 ? atsd_pkg::DEG_MAX : big[7:0];
    end
    m.avg_x = ax[9:0]; m.avg_y = ay[9:0]; m.avg_z = az[9:0];
    m.tilted = (axes != 0);
    m.tilt_axes = axes;
    m.double_tap = irq[atsd_pkg::IRQ_DOUBLE_TAP];
    m.single_tap = irq[atsd_pkg::IRQ_SINGLE_TAP] && !irq[atsd_pkg::IRQ_DOUBLE_TAP];
    m.shaken = (mag(dx) > shake_thr) || (mag(dy) > shake_thr);
    return m;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH word %0d %s: got %0d expected %0d", words_out, what, got, want);
  endtask

  // Sender side. The word stays offered until an edge sees ready high.
  task automatic send_sample(int x, int y, int z, logic [7:0] irq);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.accel_x <= x[9:0];
    sample.accel_y <= y[9:0];
    sample.accel_z <= z[9:0];
    sample.irq_source <= irq;
    do @(posedge clk); while (!sample.ready);
    expected_motion.push_back(predict_motion(x, y, z, irq));
    words_in++;
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [atsd_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v[atsd_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == atsd_pkg::REG_TILT_THR) tilt_thr = v & 9'h1FF;
    else if (idx == atsd_pkg::REG_SHAKE_THR) shake_thr = v & 10'h3FF;
    else if (idx == atsd_pkg::REG_ALPHA) alpha = v & 9'h1FF;
  endtask

  function automatic int clip(int v);
    return v > 511 ? 511 : (v < -512 ? -512 : v);
  endfunction

  task automatic send_random(int n, int spread);
    int bx, by, bz;
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) begin
        bx = $urandom_range(1023) - 512; by = $urandom_range(1023) - 512;
        bz = $urandom_range(1023) - 512;
      end
      if ($urandom_range(9) == 0)
        send_sample($urandom_range(1023) - 512, $urandom_range(1023) - 512,
                    $urandom_range(1023) - 512, $urandom_range(255));
      else
        send_sample(clip(bx + $urandom_range(2 * spread) - spread),
                    clip(by + $urandom_range(2 * spread) - spread),
                    clip(bz + $urandom_range(2 * spread) - spread), $urandom_range(255));
    end
  endtask

  task automatic test_directed();
    send_sample(511, 511, 511, 8'h40);
    send_sample(-512, -512, -512, 8'h20);
    send_sample(-512, 511, 0, 8'h60);
    send_sample(0, 0, 0, 8'h9F);
    for (int i = 0; i < 8; i++) send_sample(511, -512, 511, 8'hFF);
    for (int i = 0; i < 8; i++) send_sample(-512, 511, -512, 8'h00);
    send_sample(0, 0, 0, 8'h00);
    for (int i = 0; i < 4; i++) send_sample(0, 0, 0, 8'h00);
    drain();
  endtask

  task automatic test_registers();
    // Zero thresholds with alpha above one, then the widest values, then alpha of exactly one.
    write_reg(atsd_pkg::REG_TILT_THR, 0); write_reg(atsd_pkg::REG_SHAKE_THR, 0);
    write_reg(atsd_pkg::REG_ALPHA, 511);
    write_reg(REG_SPARE, 10'h155);
    send_random(30, 40);
    drain();
    write_reg(atsd_pkg::REG_TILT_THR, 511); write_reg(atsd_pkg::REG_SHAKE_THR, 1023);
    write_reg(atsd_pkg::REG_ALPHA, 0);
    send_random(30, 300);
    drain();
    write_reg(atsd_pkg::REG_TILT_THR, 200); write_reg(atsd_pkg::REG_SHAKE_THR, 1);
    write_reg(atsd_pkg::REG_ALPHA, 256);
    send_random(30, 60);
    drain();
  endtask

  task automatic test_idling();
    int pct_s[4] = '{0, 54, 0, 25};
    int pct_r[4] = '{0, 0, 54, 25};
    for (int p = 0; p < 4; p++) begin
      write_reg(atsd_pkg::REG_TILT_THR, $urandom_range(511));
      write_reg(atsd_pkg::REG_SHAKE_THR, $urandom_range(1023));
      write_reg(atsd_pkg::REG_ALPHA, $urandom_range(300));
      send_idle_pct = pct_s[p]; recv_stall_pct = pct_r[p];
      send_random(180, $urandom_range(200));
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    send_random(20, 50);
    // The sender pauses until everything is back.
    drain();
  endtask

  // Receiver: long hold-off counted here, otherwise random stalls.
  initial begin
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        result.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      result.ready <= !($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    motion_t want, got;
    if (!rst && result.valid && result.ready) begin
      got = '{result.avg_x, result.avg_y, result.avg_z, result.tilted, result.tilt_axes,
              result.tilt_degrees, result.single_tap, result.double_tap, result.shaken};
      words_out++;
      if (expected_motion.size() == 0) begin
        report_mismatch("unexpected result, queued words", 0, 1);
      end else begin
        want = expected_motion.pop_front();
        if (want.tilted) tilted_seen++;
        if (got.avg_x !== want.avg_x) report_mismatch("avg_x", got.avg_x, want.avg_x);
        if (got.avg_y !== want.avg_y) report_mismatch("avg_y", got.avg_y, want.avg_y);
        if (got.avg_z !== want.avg_z) report_mismatch("avg_z", got.avg_z, want.avg_z);
        if (got.tilted !== want.tilted) report_mismatch("tilted", got.tilted, want.tilted);
        if (got.tilt_axes !== want.tilt_axes)
          report_mismatch("tilt_axes", got.tilt_axes, want.tilt_axes);
        if (got.tilt_degrees !== want.tilt_degrees)
          report_mismatch("tilt_degrees", got.tilt_degrees, want.tilt_degrees);
        if (got.single_tap !== want.single_tap)
          report_mismatch("single_tap", got.single_tap, want.single_tap);
        if (got.double_tap !== want.double_tap)
          report_mismatch("double_tap", got.double_tap, want.double_tap);
        if (got.shaken !== want.shaken) report_mismatch("shaken", got.shaken, want.shaken);
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (result.valid && result.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("tb_accel_tilt_shake_tap_detector_unit: done, errors");
      $finish;
    end
  end

  initial begin
    sample.valid = 1'b0;
    sample.accel_x = '0; sample.accel_y = '0; sample.accel_z = '0; sample.irq_source = '0;
    predictor_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_idling();
    test_backpressure();
    if (expected_motion.size() != 0)
      report_mismatch("results still outstanding", expected_motion.size(), 0);
    $display("Sent %0d samples, checked %0d results, %0d of them tilted.",
             words_in, words_out, tilted_seen);
    $display("Covered threshold and alpha extremes, idle and stall phases, and a long hold-off.");
    if (errors == 0)
      $display("tb_accel_tilt_shake_tap_detector_unit: done, clean");
    else
      $display("tb_accel_tilt_shake_tap_detector_unit: done, errors");
    $finish;
  end
endmodule
